// ===== rtl/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// tun_pkg
// Shared widths and item types for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package tun_pkg;

  // vertex coordinate, edge vector, cross products
  localparam int VW  = 24;
  localparam int UW  = VW + 1;
  localparam int PRW = 2 * UW;
  localparam int NW  = PRW + 1;
  localparam int MW  = NW - 1;
  localparam int HW  = MW / 2;

  // squared lengths, root search accumulators
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;
  localparam int LW  = SW + 36;
  localparam int PW  = SW + 18;
  localparam int RW  = 16;
  localparam int OW  = 16;

  // result bits searched, one pipeline stage each
  localparam int ROOT_STEPS = RW;
  localparam logic [RW-1:0] Q15_MAX = 16'd32767;

  // one normal component during the root search
  typedef struct packed {
    logic            neg;
    logic [SQW-1:0]  sq;
    logic [LW-1:0]   l;
    logic [PW-1:0]   p;
    logic [RW-1:0]   r;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]     lane;
    logic [SW-1:0]   s;
  } root_t;

endpackage
`default_nettype wire

// ===== rtl/triangle_unit_normal_top.sv =====
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// Unit face normal of a triangle in signed Q1.15.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one triangle, three vertices in
//   signed Q16.8 (a_*, b_*, c_*). Output channel: out_valid / out_stall carry
//   norm_x, norm_y, norm_z (signed Q1.15, rounded to nearest, saturated) and
//   degenerate, which is set with a zero normal for a zero cross product.
//   From accept to out_valid an item passes the register stages for edges,
//   cross product and squared length, the square root search stages
//   (one result bit per stage), and one output register.
//   Throughput is one item per cycle; every stage is a register and no unit
//   is shared, so an item enters each cycle while out_stall is low.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall is raised in the same cycle; nothing is dropped or repeated.
//   Synchronous reset clears all valid bits; no item is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_unit_normal_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [tun_pkg::VW-1:0] a_x,
  input  wire logic signed [tun_pkg::VW-1:0] a_y,
  input  wire logic signed [tun_pkg::VW-1:0] a_z,
  input  wire logic signed [tun_pkg::VW-1:0] b_x,
  input  wire logic signed [tun_pkg::VW-1:0] b_y,
  input  wire logic signed [tun_pkg::VW-1:0] b_z,
  input  wire logic signed [tun_pkg::VW-1:0] c_x,
  input  wire logic signed [tun_pkg::VW-1:0] c_y,
  input  wire logic signed [tun_pkg::VW-1:0] c_z,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [tun_pkg::OW-1:0]      norm_x,
  output logic signed [tun_pkg::OW-1:0]      norm_y,
  output logic signed [tun_pkg::OW-1:0]      norm_z,
  output logic                               degenerate
);

  localparam int STEPS = tun_pkg::ROOT_STEPS;
  localparam int OW    = tun_pkg::OW;

  logic                 en;
  logic                 vld [STEPS+1];
  tun_pkg::root_t       stg [STEPS+1];
  logic [OW-1:0]        q   [3];
  logic                 zero_len;

  // global advance: hold everything while a result waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  tun_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (in_valid),
    .a_x  (a_x),
    .a_y  (a_y),
    .a_z  (a_z),
    .b_x  (b_x),
    .b_y  (b_y),
    .b_z  (b_z),
    .c_x  (c_x),
    .c_y  (c_y),
    .c_z  (c_z),
    .vout (vld[0]),
    .item (stg[0])
  );

  // one stage per result bit, most significant first
  for (genvar k = 0; k < STEPS; k++) begin : g_root
    tun_root_stage #(
      .BIT (STEPS - 1 - k)
    ) u_stage (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (vld[k]),
      .din  (stg[k]),
      .vout (vld[k+1]),
      .dout (stg[k+1])
    );
  end

  // sign, saturation and the zero-length case
  always_comb begin
    zero_len = (stg[STEPS].s == '0);
    for (int i = 0; i < 3; i++) begin
      if (zero_len) begin
        q[i] = '0;
      end else if (stg[STEPS].lane[i].neg) begin
        q[i] = -stg[STEPS].lane[i].r;
      end else if (stg[STEPS].lane[i].r > tun_pkg::Q15_MAX) begin
        q[i] = tun_pkg::Q15_MAX;
      end else begin
        q[i] = stg[STEPS].lane[i].r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_x     <= $signed(q[0]);
      norm_y     <= $signed(q[1]);
      norm_z     <= $signed(q[2]);
      degenerate <= zero_len;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tun_front.sv =====
// ----------------------------------------------------------------------------
// tun_front
// Edge vectors, cross product, component magnitudes and squared length.
// Seven register stages; the result seeds the square root search.
// ----------------------------------------------------------------------------
`default_nettype none
module tun_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         vin,
  input  wire logic signed [tun_pkg::VW-1:0] a_x,
  input  wire logic signed [tun_pkg::VW-1:0] a_y,
  input  wire logic signed [tun_pkg::VW-1:0] a_z,
  input  wire logic signed [tun_pkg::VW-1:0] b_x,
  input  wire logic signed [tun_pkg::VW-1:0] b_y,
  input  wire logic signed [tun_pkg::VW-1:0] b_z,
  input  wire logic signed [tun_pkg::VW-1:0] c_x,
  input  wire logic signed [tun_pkg::VW-1:0] c_y,
  input  wire logic signed [tun_pkg::VW-1:0] c_z,
  output logic                              vout,
  output tun_pkg::root_t                    item
);

  localparam int UW  = tun_pkg::UW;
  localparam int PRW = tun_pkg::PRW;
  localparam int NW  = tun_pkg::NW;
  localparam int MW  = tun_pkg::MW;
  localparam int HW  = tun_pkg::HW;
  localparam int SQW = tun_pkg::SQW;
  localparam int SW  = tun_pkg::SW;
  localparam int LW  = tun_pkg::LW;
  localparam int PW  = tun_pkg::PW;

  logic [6:0] vld;

  logic signed [UW-1:0]  u [3];
  logic signed [UW-1:0]  v [3];
  logic signed [PRW-1:0] pr [6];
  logic signed [NW-1:0]  n [3];
  logic [MW-1:0]         m [3];
  logic [2:0]            neg4;
  logic [2*HW-1:0]       hh [3];
  logic [2*HW-1:0]       hl [3];
  logic [2*HW-1:0]       ll [3];
  logic [2:0]            neg5;
  logic [SQW-1:0]        sq6 [3];
  logic [2:0]            neg6;
  logic [SW-1:0]         s7;
  logic [SQW-1:0]        sq7 [3];
  logic [2:0]            neg7;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], vin};
    end
  end

  // stage 1: edge vectors from the first vertex
  always_ff @(posedge clk) begin
    if (en) begin
      u[0] <= {b_x[23], b_x} - {a_x[23], a_x};
      u[1] <= {b_y[23], b_y} - {a_y[23], a_y};
      u[2] <= {b_z[23], b_z} - {a_z[23], a_z};
      v[0] <= {c_x[23], c_x} - {a_x[23], a_x};
      v[1] <= {c_y[23], c_y} - {a_y[23], a_y};
      v[2] <= {c_z[23], c_z} - {a_z[23], a_z};
    end
  end

  // stage 2: six cross product terms
  always_ff @(posedge clk) begin
    if (en) begin
      pr[0] <= u[1] * v[2];
      pr[1] <= u[2] * v[1];
      pr[2] <= u[2] * v[0];
      pr[3] <= u[0] * v[2];
      pr[4] <= u[0] * v[1];
      pr[5] <= u[1] * v[0];
    end
  end

  // stage 3: normal components
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n[i] <= {pr[2*i][PRW-1], pr[2*i]} - {pr[2*i+1][PRW-1], pr[2*i+1]};
      end
    end
  end

  // stage 4: sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg4[i] <= n[i][NW-1];
        m[i]    <= n[i][NW-1] ? MW'(-n[i]) : MW'(n[i]);
      end
    end
  end

  // stage 5: partial products of the squares
  always_ff @(posedge clk) begin
    if (en) begin
      neg5 <= neg4;
      for (int i = 0; i < 3; i++) begin
        hh[i] <= m[i][MW-1:HW] * m[i][MW-1:HW];
        hl[i] <= m[i][MW-1:HW] * m[i][HW-1:0];
        ll[i] <= m[i][HW-1:0] * m[i][HW-1:0];
      end
    end
  end

  // stage 6: squared components
  always_ff @(posedge clk) begin
    if (en) begin
      neg6 <= neg5;
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= {hh[i], {(2*HW){1'b0}}} + SQW'({hl[i], {(HW+1){1'b0}}})
                  + SQW'(ll[i]);
      end
    end
  end

  // stage 7: squared length and search seed
  always_ff @(posedge clk) begin
    if (en) begin
      s7   <= SW'(sq6[0]) + SW'(sq6[1]) + SW'(sq6[2]);
      neg7 <= neg6;
      for (int i = 0; i < 3; i++) begin
        sq7[i] <= sq6[i];
      end
    end
  end

  // seed: candidate 2r-1 starts at -1
  always_comb begin
    item.s = s7;
    for (int i = 0; i < 3; i++) begin
      item.lane[i].neg = neg7[i];
      item.lane[i].sq  = sq7[i];
      item.lane[i].l   = LW'(s7);
      item.lane[i].p   = PW'(-$signed({1'b0, s7}));
      item.lane[i].r   = '0;
    end
  end

  assign vout = vld[6];

endmodule
`default_nettype wire

// ===== rtl/tun_root_stage.sv =====
// ----------------------------------------------------------------------------
// tun_root_stage
// One bit of the rounded ratio m*32768/sqrt(S) for all three components.
// Tracks (2r-1)^2*S and (2r-1)*S so a trial bit needs only shifts and adds.
// ----------------------------------------------------------------------------
`default_nettype none
module tun_root_stage #(
  parameter int BIT = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            vin,
  input  wire tun_pkg::root_t  din,
  output logic                 vout,
  output tun_pkg::root_t       dout
);

  localparam int SQW = tun_pkg::SQW;
  localparam int LW  = tun_pkg::LW;
  localparam int PW  = tun_pkg::PW;

  logic signed [LW-1:0] se;
  logic signed [LW-1:0] le  [3];
  logic signed [LW-1:0] pe  [3];
  logic signed [LW-1:0] lc  [3];
  logic signed [LW-1:0] rhs [3];
  logic [2:0]           take;
  tun_pkg::root_t       dnext;

  // trial bit: (t + 2^(k+1))^2 * S against m^2 * 2^32
  always_comb begin
    se    = $signed(LW'(din.s));
    dnext = din;
    for (int i = 0; i < 3; i++) begin
      le[i]   = $signed(din.lane[i].l);
      pe[i]   = LW'($signed(din.lane[i].p));
      rhs[i]  = $signed({{(LW-SQW-32){1'b0}}, din.lane[i].sq, 32'd0});
      lc[i]   = le[i] + (pe[i] <<< (BIT + 2)) + (se <<< (2 * BIT + 2));
      take[i] = (lc[i] <= rhs[i]);
      if (take[i]) begin
        dnext.lane[i].l      = lc[i];
        dnext.lane[i].p      = din.lane[i].p + (PW'(din.s) << (BIT + 1));
        dnext.lane[i].r[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dnext;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tun_checker.sv =====
// ----------------------------------------------------------------------------
// tun_checker
// Port-level checks on the triangle unit normal, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module tun_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [tun_pkg::OW-1:0] norm_x,
  input wire logic signed [tun_pkg::OW-1:0] norm_y,
  input wire logic signed [tun_pkg::OW-1:0] norm_z,
  input wire logic                          degenerate
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(norm_x) && $stable(norm_y)
      && $stable(norm_z) && $stable(degenerate))
    else $error("stalled item changed");

  // degenerate item carries a zero normal
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> norm_x == 0 && norm_y == 0 && norm_z == 0)
    else $error("degenerate item with nonzero normal");

  // a real normal has at least one nonzero component
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> norm_x != 0 || norm_y != 0 || norm_z != 0)
    else $error("zero normal without degenerate flag");

  // input is held back only by a stalled result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind triangle_unit_normal_top tun_checker u_tun_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .norm_x     (norm_x),
  .norm_y     (norm_y),
  .norm_z     (norm_z),
  .degenerate (degenerate)
);
`default_nettype wire
